// ===== hdl/rlpf_pkg.sv =====
// Shared types, constants and the quarter-wave cosine table of the resonant lowpass filter.
// No dependencies; every other file of the block imports this package.
package rlpf_pkg;

    localparam int COEFF_INTERVAL  = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int COS_TABLE_DEPTH = 1024;

    localparam int CNT_W        = $clog2(COEFF_INTERVAL + 1);
    localparam int COS_IDX_BITS = $clog2(COS_TABLE_DEPTH);
    localparam int COS_QTR      = COS_TABLE_DEPTH / 4;
    localparam int COS_K_BITS   = COS_IDX_BITS - 2;

    // Serial arithmetic unit widths
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIV_NUM_W = 60;
    localparam int DIV_DEN_W = 32;

    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF      = 2'd0,
        CFG_RESONANCE   = 2'd1,
        CFG_SAMPLE_RATE = 2'd2
    } t_cfg_index;

    localparam logic [29:0] TWOPI_Q27   = 30'd843314857;
    localparam logic [25:0] POINT3_Q27  = 26'd40265318;
    localparam logic [27:0] ONE_Q27     = 28'h800_0000;
    localparam logic [17:0] MIN_RATE    = 18'd8000;
    localparam logic [17:0] RESET_RATE  = 18'd44100;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] audio_in;
        logic signed [15:0]            cutoff_cv;
        logic signed [15:0]            emphasis_cv;
        logic                          first_of_block;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] audio_out;
        logic                          clipped;
    } t_out_word;

    typedef logic [COS_QTR:0][30:0] t_cos_tab;

    // Q30 cosine of u/2^32 turns, u in 0..2^30: truncated 9-term series
    function automatic logic [30:0] cos_quarter(input logic [31:0] u);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [64:0] sum;
        x    = ({32'd0, u} * 64'(TWOPI_Q27)) >> 29;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = 65'sd1 <<< 30;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k[0]) begin
                sum = sum - $signed({1'b0, term});
            end else begin
                sum = sum + $signed({1'b0, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end else if (sum > (65'sd1 <<< 30)) begin
            sum = 65'sd1 <<< 30;
        end
        return sum[30:0];
    endfunction

    function automatic t_cos_tab build_cos_tab();
        t_cos_tab tab;
        for (int k = 0; k <= COS_QTR; k++) begin
            tab[k] = cos_quarter(32'(k) << (32 - COS_IDX_BITS));
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

endpackage

// ===== hdl/resonant_lowpass_filter.sv =====
// Resonant two-pole lowpass filter: top level with sequencer, state and output register.
// Depends on rlpf_pkg, rlpf_serial_mul and rlpf_serial_div.
//
// One word in, one word out. The block works on one word at a time through a shared
// bit-serial multiplier and a bit-serial divider. An ordinary sample takes three
// products. The first sample of each group of ten (and any sample flagged first_of_block)
// also recomputes the coefficients: three quotients and three more products. The next
// word is accepted as soon as the result is in the output register, whether or not the
// consumer has taken it yet.
module resonant_lowpass_filter import rlpf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_TURNS, S_OMEGA, S_INV, S_QDIV, S_QSQ, S_CWQ,
        S_DRIVE, S_VEL, S_DAMP, S_EMIT
    } t_state;

    localparam logic signed [33:0] POS_ONE = 34'sd134217728;
    localparam logic signed [31:0] OUT_MAX = 32'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [31:0] OUT_MIN = -OUT_MAX - 32'sd1;

    function automatic logic [16:0] clamp_level(input logic [15:0] knob,
                                                input logic signed [15:0] cv);
        logic signed [18:0] sum;
        sum = $signed({3'b000, knob}) + (19'(cv) <<< 1);
        if (sum < 0) begin
            return 17'd0;
        end else if (sum > 19'sd65536) begin
            return 17'h1_0000;
        end
        return sum[16:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Configuration registers
    logic [15:0] r_cutoff_level;
    logic [15:0] r_resonance_level;
    logic [17:0] r_sample_rate;

    // Control and filter state
    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    t_out_word               r_out;
    logic signed [31:0]      r_position;
    logic signed [31:0]      r_velocity;
    logic signed [31:0]      r_drive_coeff;
    logic signed [31:0]      r_damping_coeff;

    // Per-word working registers
    logic signed [SAMPLE_BITS-1:0] r_a;
    logic [16:0]             r_res;
    logic [32:0]             r_turns;
    logic [30:0]             r_w;
    logic signed [31:0]      r_cw;
    logic [27:0]             r_q;
    t_out_word               r_pend;

    // Arithmetic unit hookup
    logic                     mul_start;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     div_start;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_quo;

    logic                     in_acc;
    logic                     upd;
    logic [CNT_W-1:0]         cnt_base;
    logic [CNT_W-1:0]         cnt_inc;
    logic [CNT_W-1:0]         cnt_next;
    logic [16:0]              f_in;
    logic [16:0]              res_in;
    logic [29:0]              freq_q16;
    logic [17:0]              fs;
    logic [30:0]              w_val;
    logic [32:0]              den_sum;
    logic [27:0]              q_val;
    logic signed [PROD_W-1:0] prod_shd;
    logic signed [PROD_W-1:0] prod_sh27;
    logic signed [PROD_W-1:0] prod_sh29;
    logic signed [33:0]       c_sum;
    logic signed [33:0]       err_val;
    logic signed [33:0]       vel_sum;
    logic signed [31:0]       vel_c;
    logic signed [33:0]       pos_sum;
    logic signed [31:0]       pos_c;
    logic                     clip;
    logic signed [31:0]       out_sh;
    logic signed [31:0]       out_c;
    logic [COS_IDX_BITS:0]    idx_sum;
    logic [COS_IDX_BITS-1:0]  cos_idx;
    logic [COS_K_BITS:0]      tab_idx;
    logic [31:0]              cos_mag;
    logic signed [31:0]       cos_val;

    rlpf_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    rlpf_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_level    <= '0;
            r_resonance_level <= '0;
            r_sample_rate     <= RESET_RATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CUTOFF:      r_cutoff_level    <= i_cfg_data[15:0];
                CFG_RESONANCE:   r_resonance_level <= i_cfg_data[15:0];
                CFG_SAMPLE_RATE: r_sample_rate     <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        upd      = i_in_data.first_of_block || (r_cnt == '0);
        cnt_base = i_in_data.first_of_block ? '0 : r_cnt;
        cnt_inc  = cnt_base + 1'b1;
        cnt_next = (cnt_inc == CNT_W'(COEFF_INTERVAL)) ? '0 : cnt_inc;

        f_in     = clamp_level(r_cutoff_level, i_in_data.cutoff_cv);
        res_in   = clamp_level(r_resonance_level, i_in_data.emphasis_cv);
        freq_q16 = 30'(f_in) * 30'd10000 + 30'd65536;
        fs       = (r_sample_rate < MIN_RATE) ? MIN_RATE : r_sample_rate;

        w_val    = mul_prod[62:32];
        den_sum  = (33'(r_res) << 15) + (33'(r_res) << 13) + 33'(r_w) + 33'(div_quo[27:0]);
        q_val    = ONE_Q27 - div_quo[27:0];

        prod_shd  = mul_prod >>> (SAMPLE_BITS - 1);
        prod_sh27 = mul_prod >>> 27;
        prod_sh29 = mul_prod >>> 29;

        c_sum   = 34'(r_damping_coeff) + 34'(ONE_Q27) - prod_sh29[33:0];
        err_val = prod_shd[33:0] - 34'(r_position);
        vel_sum = 34'(r_velocity) + prod_sh27[33:0];
        vel_c   = sat32(vel_sum);
        pos_sum = 34'(r_position) + 34'(vel_c);
        clip    = 1'b0;
        pos_c   = pos_sum[31:0];
        if (pos_sum > POS_ONE) begin
            pos_c = POS_ONE[31:0];
            clip  = 1'b1;
        end else if (pos_sum < -POS_ONE) begin
            pos_c = -POS_ONE[31:0];
            clip  = 1'b1;
        end
        out_sh = pos_c >>> (28 - SAMPLE_BITS);
        if (out_sh > OUT_MAX) begin
            out_c = OUT_MAX;
        end else if (out_sh < OUT_MIN) begin
            out_c = OUT_MIN;
        end else begin
            out_c = out_sh;
        end

        // Round the turn fraction to the table grid, then fold by quadrant
        idx_sum = {1'b0, r_turns[31:32-COS_IDX_BITS]} + (COS_IDX_BITS + 1)'(r_turns[31-COS_IDX_BITS]);
        cos_idx = idx_sum[COS_IDX_BITS-1:0];
        if (cos_idx[COS_IDX_BITS-2]) begin
            tab_idx = (COS_K_BITS + 1)'(COS_QTR) - {1'b0, cos_idx[COS_K_BITS-1:0]};
        end else begin
            tab_idx = {1'b0, cos_idx[COS_K_BITS-1:0]};
        end
        cos_mag = 32'(COS_TAB[tab_idx]);
        if (cos_idx[COS_IDX_BITS-1] ^ cos_idx[COS_IDX_BITS-2]) begin
            cos_val = -$signed(cos_mag);
        end else begin
            cos_val = $signed(cos_mag);
        end
    end

    // Issue the next serial operation as the previous one finishes
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && upd) begin
                    div_start = 1'b1;
                    div_num   = DIV_NUM_W'(freq_q16) << 16;
                    div_den   = DIV_DEN_W'(fs);
                end else if (in_acc) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(i_in_data.audio_in);
                    mul_b     = MUL_W'(POINT3_Q27);
                end
            end
            S_TURNS: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(div_quo[32:0]);
                    mul_b     = MUL_W'(TWOPI_Q27);
                end
            end
            S_OMEGA: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_num   = DIV_NUM_W'(1) << 54;
                    div_den   = DIV_DEN_W'(ONE_Q27) + DIV_DEN_W'(w_val);
                end
            end
            S_INV: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = DIV_NUM_W'(r_w) << 27;
                    div_den   = den_sum[DIV_DEN_W-1:0];
                end
            end
            S_QDIV: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(q_val);
                    mul_b     = MUL_W'(q_val);
                end
            end
            S_QSQ: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(r_cw);
                    mul_b     = MUL_W'(r_q);
                end
            end
            S_CWQ: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(r_a);
                    mul_b     = MUL_W'(POINT3_Q27);
                end
            end
            S_DRIVE: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = err_val;
                    mul_b     = MUL_W'(r_drive_coeff);
                end
            end
            S_VEL: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(vel_c);
                    mul_b     = MUL_W'(r_damping_coeff);
                end
            end
            S_DAMP, S_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
            r_position      <= '0;
            r_velocity      <= '0;
            r_drive_coeff   <= '0;
            r_damping_coeff <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_a     <= i_in_data.audio_in;
                        r_res   <= res_in;
                        r_cnt   <= cnt_next;
                        r_state <= upd ? S_TURNS : S_DRIVE;
                    end
                end
                S_TURNS: begin
                    if (div_done) begin
                        r_turns <= div_quo[32:0];
                        r_state <= S_OMEGA;
                    end
                end
                S_OMEGA: begin
                    if (mul_done) begin
                        r_w     <= w_val;
                        r_cw    <= cos_val;
                        r_state <= S_INV;
                    end
                end
                S_INV: begin
                    if (div_done) begin
                        r_state <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (div_done) begin
                        r_q     <= q_val;
                        r_state <= S_QSQ;
                    end
                end
                S_QSQ: begin
                    if (mul_done) begin
                        r_damping_coeff <= prod_sh27[31:0];
                        r_state         <= S_CWQ;
                    end
                end
                S_CWQ: begin
                    if (mul_done) begin
                        r_drive_coeff <= c_sum[31:0];
                        r_state       <= S_DRIVE;
                    end
                end
                S_DRIVE: begin
                    if (mul_done) begin
                        r_state <= S_VEL;
                    end
                end
                S_VEL: begin
                    if (mul_done) begin
                        r_position       <= pos_c;
                        r_pend.audio_out <= out_c[SAMPLE_BITS-1:0];
                        r_pend.clipped   <= clip;
                        r_state          <= S_DAMP;
                    end
                end
                S_DAMP: begin
                    if (mul_done) begin
                        r_velocity <= sat32(prod_sh27[33:0]);
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/rlpf_serial_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle.
// Depends on rlpf_pkg for the operand and product widths.
module rlpf_serial_mul import rlpf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_prod
);

    localparam int CNT_BITS = $clog2(MUL_W);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_BITS-1:0]      r_cnt;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_mcand;
    logic [MUL_W-1:0]         r_mplier;
    logic signed [PROD_W-1:0] n_acc;

    // The sign bit of the multiplier carries negative weight
    always_comb begin
        n_acc = r_acc;
        if (r_mplier[0]) begin
            if (r_cnt == CNT_BITS'(MUL_W - 1)) begin
                n_acc = r_acc - r_mcand;
            end else begin
                n_acc = r_acc + r_mcand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PROD_W'(i_a);
            r_mplier <= i_b;
        end else if (r_busy) begin
            r_acc    <= n_acc;
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/rlpf_serial_div.sv =====
// Bit-serial restoring divider for unsigned operands: one quotient bit per cycle.
// Depends on rlpf_pkg for the numerator and divisor widths.
module rlpf_serial_div import rlpf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    localparam int CNT_BITS = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 qbit;
    logic [DIV_DEN_W-1:0] n_rem;

    // Bring down the next numerator bit, subtract when it fits
    always_comb begin
        shifted = {r_rem, r_quo[DIV_NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        qbit    = (shifted >= {1'b0, r_den});
        n_rem   = qbit ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], qbit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
